// ===== src/alc_pkg.sv =====
// Shared types and constants for the ambient light lux conditioner.
package alc_pkg;

    localparam int RAW_W   = 16;
    localparam int LUX_W   = 28;
    localparam int MULT_W  = 12;
    localparam int RES_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int WCNT_W  = 3;

    localparam logic [WCNT_W-1:0] WIN_LEN    = 3'd5;
    localparam logic [LUX_W-1:0]  WIN_RELOAD = 28'h7ffffff;

    // two quotient bits per divider step
    localparam int DIV_STEPS = LUX_W / 2;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RES    = 3'd4;

    localparam logic [MULT_W-1:0] MULT_RST = 12'd656;
    localparam logic [MULT_W-1:0] DIV_RST  = 12'd100;
    localparam logic [RES_W-1:0]  RES_RST  = 10'd50;

    localparam logic DIV_SEL_SCALE = 1'b0;
    localparam logic DIV_SEL_RES   = 1'b1;

    typedef struct packed {
        logic clr_valid;
        logic load;
        logic mul;
        logic div_step;
        logic div_sel;
        logic rnd;
        logic scale;
        logic update;
    } t_cmd;

    typedef struct packed {
        logic stall;
        logic last_valid;
    } t_sts;

endpackage

// ===== src/alc_ctrl.sv =====
// Sequencing controller for the lux conditioner datapath.
module alc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_action,
    input  logic           i_failed,
    output logic           o_in_ready,
    output alc_pkg::t_cmd  o_cmd,
    input  alc_pkg::t_sts  i_sts
);
    import alc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_RND1  = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_RND2  = 3'd5;
    localparam logic [2:0] S_SCALE = 3'd6;
    localparam logic [2:0] S_UPD   = 3'd7;

    logic [2:0]        r_state, n_state;
    logic [DCNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action) begin
                        o_cmd.clr_valid = 1'b1;
                    end else if (!i_failed) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = DIV_LAST;
                n_state   = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel  = DIV_SEL_SCALE;
                if (r_cnt == '0) begin
                    n_state = S_RND1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_RND1: begin
                o_cmd.rnd     = 1'b1;
                o_cmd.div_sel = DIV_SEL_SCALE;
                n_cnt         = DIV_LAST;
                n_state       = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_sel  = DIV_SEL_RES;
                if (r_cnt == '0) begin
                    n_state = S_RND2;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_RND2: begin
                o_cmd.rnd     = 1'b1;
                o_cmd.div_sel = DIV_SEL_RES;
                n_state       = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_UPD;
            end
            S_UPD: begin
                // hold here while a new report is due but the output stage is full
                if (!i_sts.stall) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/alc_dpath.sv =====
// Datapath: config registers, compensation, scaling divider, report state, output stage.
module alc_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [alc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [alc_pkg::RAW_W-1:0]      i_raw,
    input  alc_pkg::t_cmd                  i_cmd,
    output alc_pkg::t_sts                  o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [alc_pkg::LUX_W-1:0]      o_out_lux,
    output logic                           o_out_win
);
    import alc_pkg::*;

    logic              r_blink;
    logic [RAW_W-1:0]  r_offset;
    logic [MULT_W-1:0] r_mult;
    logic [MULT_W-1:0] r_div;
    logic [RES_W-1:0]  r_res;

    logic [RAW_W-1:0]  r_v;
    logic [LUX_W-1:0]  r_x;
    logic [MULT_W-1:0] r_rem;

    logic [LUX_W-1:0]  r_last;
    logic              r_last_valid;
    logic [LUX_W-1:0]  r_wmin;
    logic [WCNT_W-1:0] r_wcnt;

    logic              r_out_valid;
    logic [LUX_W-1:0]  r_out_lux;
    logic              r_out_win;

    function automatic logic [MULT_W:0] f_step(input logic [MULT_W-1:0] rem,
                                               input logic b,
                                               input logic [MULT_W-1:0] d);
        logic [MULT_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, d}) begin
            f_step = {1'b1, MULT_W'(t - {1'b0, d})};
        end else begin
            f_step = {1'b0, t[MULT_W-1:0]};
        end
    endfunction

    // compensation of the raw count
    logic signed [RAW_W:0] w_diff;
    logic [6:0]            w_x3;
    logic [RAW_W-1:0]      w_comp;

    always_comb begin
        w_diff = $signed({1'b0, i_raw})
               - $signed({1'b0, (r_blink ? {RAW_W{1'b0}} : r_offset)});
        w_x3   = {1'b0, w_diff[4:0], 1'b0} + {2'b00, w_diff[4:0]};
        if (w_diff < 0) begin
            w_comp = '0;
        end else if (w_diff < 17'sd8) begin
            w_comp = {w_diff[RAW_W-2:0], 1'b0};
        end else if (w_diff < 17'sd24) begin
            w_comp = RAW_W'(w_x3[6:1]);
        end else begin
            w_comp = w_diff[RAW_W-1:0];
        end
    end

    // divider
    logic [MULT_W-1:0] w_d;
    logic [MULT_W:0]   w_s1, w_s2;
    logic              w_rnd_up;
    logic [RES_W-1:0]  w_res;

    always_comb begin
        w_res = (r_res == '0) ? RES_W'(1) : r_res;
        if (i_cmd.div_sel == DIV_SEL_RES) begin
            w_d = MULT_W'(w_res);
        end else begin
            w_d = (r_div == '0) ? MULT_W'(1) : r_div;
        end
        w_s1     = f_step(r_rem, r_x[LUX_W-1], w_d);
        w_s2     = f_step(w_s1[MULT_W-1:0], r_x[LUX_W-2], w_d);
        w_rnd_up = ({r_rem, 1'b0} >= {1'b0, w_d});
    end

    // report decision
    logic [LUX_W-1:0] w_new_min;
    logic [LUX_W-1:0] w_val;
    logic             w_emit;
    logic             w_pos0;

    always_comb begin
        w_new_min = (r_x <= r_wmin) ? r_x : r_wmin;
        w_pos0    = (r_wcnt == '0);
        if (r_blink) begin
            w_val  = w_new_min;
            w_emit = w_pos0 && (!r_last_valid || (r_last != w_new_min));
        end else begin
            w_val  = r_x;
            w_emit = !r_last_valid || (r_x != r_last);
        end
        o_sts.stall      = w_emit && r_out_valid && !i_out_ready;
        o_sts.last_valid = r_last_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink      <= 1'b0;
            r_offset     <= '0;
            r_mult       <= MULT_RST;
            r_div        <= DIV_RST;
            r_res        <= RES_RST;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_wmin       <= WIN_RELOAD;
            r_wcnt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BLINK:  r_blink  <= i_cfg_data[0];
                    CFG_OFFSET: r_offset <= i_cfg_data[RAW_W-1:0];
                    CFG_MULT:   r_mult   <= i_cfg_data[MULT_W-1:0];
                    CFG_DIV:    r_div    <= i_cfg_data[MULT_W-1:0];
                    CFG_RES:    r_res    <= i_cfg_data[RES_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clr_valid) begin
                r_last_valid <= 1'b0;
            end
            if (i_cmd.update) begin
                if (w_emit) begin
                    r_last       <= w_val;
                    r_last_valid <= 1'b1;
                end
                if (r_blink) begin
                    r_wmin <= w_pos0 ? WIN_RELOAD : w_new_min;
                    r_wcnt <= (r_wcnt == WIN_LEN - 1'b1) ? '0 : r_wcnt + 1'b1;
                end
            end
            if (i_cmd.update && w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v <= w_comp;
        end
        if (i_cmd.mul) begin
            r_x   <= LUX_W'(r_v) * LUX_W'(r_mult);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_x   <= {r_x[LUX_W-3:0], w_s1[MULT_W], w_s2[MULT_W]};
            r_rem <= w_s2[MULT_W-1:0];
        end else if (i_cmd.rnd) begin
            r_x   <= r_x + LUX_W'(w_rnd_up);
            r_rem <= '0;
        end else if (i_cmd.scale) begin
            r_x <= LUX_W'(r_x * w_res);
        end
        if (i_cmd.update && w_emit) begin
            r_out_lux <= w_val;
            r_out_win <= r_blink;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_lux   = r_out_lux;
    assign o_out_win   = r_out_win;

endmodule

// ===== src/ambient_light_lux_conditioner_core.sv =====
// Ambient light lux conditioner: top level joining controller and datapath.
//
// Input stream (s_axis): tdata carries the raw 16-bit light count, tuser bit 0
// is the action (0 poll, 1 report on) and bit 1 flags a failed sensor read.
// Output stream (m_axis): tdata[27:0] is the reported lux value, tuser is 1
// when the report is a blink-window minimum. At most one report per poll.
// Config channel: i_cfg_index selects the register (0 blink mode, 1 LED
// offset, 2 scale mult, 3 scale div, 4 resolution); always ready; write only
// while the block is idle.
// A report-on or failed-read transaction is handled in the idle state. A good
// poll runs the product through one shared radix-4 divider twice, first by the
// scale divisor and then by the resolution, then scales and updates the report
// before the controller returns to idle and can take the next transaction.
// The output stage holds a report until taken; a new poll may be accepted
// meanwhile, and only stalls at its own final step if the stage is still full.
// Reset (synchronous, active low) restores register defaults, clears the last
// report and reloads the window minimum; no clearing pass is needed.
module ambient_light_lux_conditioner_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] raw_count
    input  logic [1:0]  s_axis_tuser,   // [0] action, [1] read_failed
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [27:0] lux_value, [31:28] zero
    output logic        m_axis_tuser,   // [0] from_window
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [alc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [alc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import alc_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [LUX_W-1:0] w_lux;

    assign o_cfg_ready = 1'b1;

    alc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_action   (s_axis_tuser[0]),
        .i_failed   (s_axis_tuser[1]),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    alc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_raw       (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_lux   (w_lux),
        .o_out_win   (m_axis_tuser)
    );

    assign m_axis_tdata = {4'b0000, w_lux};

    // a good poll occupies the controller for the following cycle
    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !s_axis_tuser[1])
        |=> !s_axis_tready)
        else $error("input ready after accepting a poll");

    // a fresh report always leaves a valid last report behind
    a_report_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> w_sts.last_valid)
        else $error("report issued without last report marked valid");

    // a window minimum can never exceed the reload value
    a_win_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (w_lux <= WIN_RELOAD))
        else $error("window report above reload value");

endmodule
